// ===== sv/sb64d_pkg.sv =====
// shared types, constants and the alphabet lookup for the base64 stream decoder
// no dependencies; imported by every module of the block
package sb64d_pkg;

  typedef enum logic [1:0] {
    ST_BYTE = 2'd0,
    ST_OK   = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='
  localparam logic [1:0] POS_LAST = 2'd3;

  // results caused by one character: up to three bytes and an optional status word
  typedef struct packed {
    logic [2:0][7:0] bytes;        // bytes[0] leaves first
    logic [1:0]      nbytes;
    logic [2:0]      nres;         // nbytes plus one when a status word follows
    status_t         tail_status;
  } rec_t;

  // returns {valid, sextet}
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    begin
      r = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin
        r = {1'b1, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        r = {1'b1, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
        r = {1'b1, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2B) begin
        r = {1'b1, 6'd62};
      end else if (c == 8'h2F) begin
        r = {1'b1, 6'd63};
      end
      return r;
    end
  endfunction

endpackage

// ===== sv/sb64d_decode.sv =====
// input register, group state and decode logic of the base64 stream decoder
// depends on sb64d_pkg; hands at most one result record per character to sb64d_outq
module sb64d_decode import sb64d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_end_of_text,
  output logic       rec_push,
  output rec_t       rec,
  input  logic       rec_room
);

  logic        inq_valid_r;
  logic [7:0]  char_r;
  logic        end_r;
  logic [1:0]  pos_r, pos_nxt;
  logic [17:0] acc_r, acc_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        failed_r, failed_nxt;

  logic        has_res;
  logic        fire;
  logic [6:0]  sx;
  logic        is_pad;
  logic [1:0]  pad_inc;
  logic [1:0]  pads;
  logic [23:0] v;
  logic        bad_char;
  logic        bad_pad;

  assign fire     = inq_valid_r && (!has_res || rec_room);
  assign in_ready = !inq_valid_r || fire;
  assign rec_push = fire && has_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_ready) begin
      inq_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      char_r <= in_char;
      end_r  <= in_end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      acc_r    <= '0;
      pad_r    <= '0;
      failed_r <= 1'b0;
    end else if (fire) begin
      pos_r    <= pos_nxt;
      acc_r    <= acc_nxt;
      pad_r    <= pad_nxt;
      failed_r <= failed_nxt;
    end
  end

  always_comb begin
    sx       = sextet_of(char_r);
    is_pad   = (char_r == PAD_CHAR);
    pad_inc  = pad_r + 2'd1;
    v        = {acc_r, (is_pad ? 6'd0 : sx[5:0])};
    bad_char = is_pad ? (pos_r < 2'd2) : ((pad_r != 2'd0) || !sx[6]);
    pads     = is_pad ? pad_inc : pad_r;
    // two pads: low 4 bits of second sextet; one pad: low 2 bits of third
    bad_pad  = ((pads == 2'd2) && (v[15:12] != 4'd0)) ||
               ((pads == 2'd1) && (v[7:6] != 2'd0)) ||
               ((pads != 2'd0) && !end_r);

    pos_nxt    = pos_r;
    acc_nxt    = acc_r;
    pad_nxt    = pad_r;
    failed_nxt = failed_r;
    has_res    = 1'b0;
    rec        = '0;
    rec.tail_status = ST_ERR;

    if (failed_r) begin
      // swallow until end of text
      if (end_r) begin
        failed_nxt = 1'b0;
      end
    end else if (bad_char || (pos_r != POS_LAST && end_r) ||
                 (pos_r == POS_LAST && bad_pad)) begin
      has_res         = 1'b1;
      rec.nres        = 3'd1;
      rec.tail_status = ST_ERR;
      pos_nxt         = '0;
      acc_nxt         = '0;
      pad_nxt         = '0;
      failed_nxt      = !end_r;
    end else if (pos_r != POS_LAST) begin
      acc_nxt = v[17:0];
      pos_nxt = pos_r + 2'd1;
      pad_nxt = pads;
    end else begin
      has_res         = 1'b1;
      rec.bytes       = {v[7:0], v[15:8], v[23:16]};
      rec.nbytes      = 2'(2'd3 - pads);
      rec.nres        = {1'b0, rec.nbytes} + {2'b00, end_r};
      rec.tail_status = ST_OK;
      pos_nxt         = '0;
      acc_nxt         = '0;
      pad_nxt         = '0;
    end
  end

  a_failed_clear: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> (pos_r == 2'd0 && pad_r == 2'd0))
    else $error("failed text left group state behind");

  a_pad_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (pad_r != 2'd0) |-> (pad_r == 2'd1 && pos_r == POS_LAST))
    else $error("stored pad count outside the last place of a group");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    rec_push |-> rec_room)
    else $error("record pushed into a full queue");

endmodule

// ===== sv/sb64d_outq.sv =====
// two-entry record queue and serialiser that hands out one result word per cycle while out_ready is high
// depends on sb64d_pkg; fed by sb64d_decode
module sb64d_outq import sb64d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rec_push,
  input  rec_t       rec,
  output logic       rec_room,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic [1:0] out_status,
  output logic       out_last_of_run
);

  rec_t       q_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;
  logic [1:0] idx_r;
  rec_t       head;
  logic       take;
  logic       pop;
  logic       is_byte;

  assign head      = q_r[rd_r];
  assign rec_room  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign take      = out_valid && out_ready;
  assign pop       = take && out_last_of_run;

  assign is_byte         = (idx_r < head.nbytes);
  assign out_data_byte   = is_byte ? head.bytes[idx_r] : 8'd0;
  assign out_status      = is_byte ? ST_BYTE : head.tail_status;
  assign out_last_of_run = ({1'b0, idx_r} == 3'(head.nres - 3'd1));

  always_ff @(posedge clk) begin
    if (rec_push) begin
      q_r[wr_r] <= rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      if (rec_push) begin
        wr_r <= !wr_r;
      end
      if (pop) begin
        rd_r <= !rd_r;
      end
      cnt_r <= cnt_r + {1'b0, rec_push} - {1'b0, pop};
      if (take) begin
        idx_r <= out_last_of_run ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("record queue overfilled");

  a_idx_in_record: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (head.nres != 3'd0 && {1'b0, idx_r} < head.nres))
    else $error("serialiser index beyond its record");

endmodule

// ===== sv/strict_base64_stream_decoder_top.sv =====
// top level of the strict base64 stream decoder
// depends on sb64d_pkg, sb64d_decode and sb64d_outq
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | in_char, in_end_of_text
//   out_    | output    | out_valid / out_ready | out_data_byte, out_status, out_last_of_run
//
// one character is taken per cycle while in_ready is high; it is held in the input
// register, and its results leave the record queue one word per cycle while out_ready is high
// the last character of a group causes up to four words, drained from a
// two-record queue while later characters keep flowing
// rst_n clears the group state, the failed flag and both queues at once
// a stalled output fills the queue, then in_ready drops once a character with results waits
module strict_base64_stream_decoder_top import sb64d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic [1:0] out_status,
  output logic       out_last_of_run
);

  logic rec_push;
  rec_t rec;
  logic rec_room;

  sb64d_decode u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char        (in_char),
    .in_end_of_text (in_end_of_text),
    .rec_push       (rec_push),
    .rec            (rec),
    .rec_room       (rec_room)
  );

  sb64d_outq u_outq (
    .clk             (clk),
    .rst_n           (rst_n),
    .rec_push        (rec_push),
    .rec             (rec),
    .rec_room        (rec_room),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_byte   (out_data_byte),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run)
  );

endmodule
